// File: src/gke_pkg.sv
// ----------------------------------------------------------------------------
// gke_pkg
// Shared types and constants for the GF(2) kernel basis elimination block.
// ----------------------------------------------------------------------------
`default_nettype none

package gke_pkg;

  localparam int unsigned VecPortW = 64;
  localparam int unsigned TagW     = 64;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned CountW   = 7;

  // dependent count saturates here
  localparam logic [CountW-1:0] CountMax = 7'd64;

  typedef struct packed {
    logic                start_new;
    logic [VecPortW-1:0] vector_in;
    logic [TagW-1:0]     combination_in;
    logic                last_in_set;
  } item_t;

  typedef struct packed {
    logic              dependent;
    logic [TagW-1:0]   kernel_vector;
    logic [SlotW-1:0]  pivot_slot;
    logic [CountW-1:0] kernel_count;
    logic              dimension_mismatch;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new item
    logic step;        // move scan position down one bit
    logic apply;       // xor fetched pivot into vector and tag
    logic store;       // keep remainder as new pivot, finish
    logic finish_dep;  // remainder is zero, finish
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic vec_zero;
    logic bit_set;
    logic slot_valid;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/gke_ram.sv
// ----------------------------------------------------------------------------
// gke_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gke_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/gke_ctrl.sv
// ----------------------------------------------------------------------------
// gke_ctrl
// Sequencer for the bit-serial reduction: scan, fetch pivot, finish.
// ----------------------------------------------------------------------------
`default_nettype none

module gke_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire gke_pkg::dp_status_t status,
  output gke_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_XOR
  } state_t;

  state_t state;
  logic   finish;

  assign finish = status.vec_zero || (status.bit_set && !status.slot_valid);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SCAN: begin
        if (status.vec_zero) begin
          cmd.finish_dep = 1'b1;
        end else if (status.bit_set && !status.slot_valid) begin
          cmd.store = 1'b1;
        end else if (!status.bit_set) begin
          cmd.step = 1'b1;
        end
      end
      ST_XOR: begin
        cmd.apply = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            busy  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else if (status.bit_set) begin
            // pivot read is issued this cycle, data lands next cycle
            state <= ST_XOR;
          end
        end
        ST_XOR: begin
          state <= ST_SCAN;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/gke_datapath.sv
// ----------------------------------------------------------------------------
// gke_datapath
// Working vector and tag, scan position, pivot table with valid bits,
// dependent count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gke_datapath #(
  parameter int unsigned VECTOR_WIDTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire gke_pkg::item_t                     item,
  input  wire logic                               cfg_we,
  input  wire logic [gke_pkg::CountW-1:0]         cfg_data,
  input  wire gke_pkg::dp_cmd_t                   cmd,
  output gke_pkg::dp_status_t                     status,
  output gke_pkg::result_t                        result
);

  localparam int unsigned AW   = $clog2(VECTOR_WIDTH);
  localparam int unsigned RamW = VECTOR_WIDTH + gke_pkg::TagW;

  logic [VECTOR_WIDTH-1:0]    vec;
  logic [gke_pkg::TagW-1:0]   tag;
  logic [AW-1:0]              pos;
  logic                       last;
  logic [VECTOR_WIDTH-1:0]    valid;
  logic [gke_pkg::CountW-1:0] count;
  logic [gke_pkg::CountW-1:0] count_next;
  logic [gke_pkg::CountW-1:0] expected;
  logic [RamW-1:0]            rdata;
  logic [VECTOR_WIDTH-1:0]    piv_vec;
  logic [gke_pkg::TagW-1:0]   piv_tag;

  assign piv_vec = rdata[RamW-1:gke_pkg::TagW];
  assign piv_tag = rdata[gke_pkg::TagW-1:0];

  assign status.vec_zero   = (vec == '0);
  assign status.bit_set    = vec[pos];
  assign status.slot_valid = valid[pos];

  assign count_next = (count < gke_pkg::CountMax) ? count + 1'b1 : count;

  // pivot table, read address follows the scan position
  gke_ram #(
    .WIDTH (RamW),
    .DEPTH (VECTOR_WIDTH)
  ) u_pivots (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (pos),
    .wdata ({vec, tag}),
    .raddr (pos),
    .rdata (rdata)
  );

  // control state: valid bits, count, expected dimension
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= '0;
      expected <= '0;
    end else begin
      if (cfg_we) begin
        expected <= cfg_data;
      end
      if (cmd.load && item.start_new) begin
        valid <= '0;
        count <= '0;
      end else if (cmd.store) begin
        valid[pos] <= 1'b1;
      end else if (cmd.finish_dep) begin
        count <= count_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vec  <= item.vector_in[VECTOR_WIDTH-1:0];
      tag  <= item.combination_in;
      pos  <= AW'(VECTOR_WIDTH - 1);
      last <= item.last_in_set;
    end else if (cmd.step) begin
      pos <= pos - AW'(1);
    end else if (cmd.apply) begin
      // pivot leads at pos, so this clears the current top bit
      vec <= vec ^ piv_vec;
      tag <= tag ^ piv_tag;
      if (pos != '0) begin
        pos <= pos - AW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      result.dependent          <= 1'b0;
      result.kernel_vector      <= tag;
      result.pivot_slot         <= gke_pkg::SlotW'(pos);
      result.kernel_count       <= count;
      result.dimension_mismatch <= last && (count != expected);
    end else if (cmd.finish_dep) begin
      result.dependent          <= 1'b1;
      result.kernel_vector      <= tag;
      result.pivot_slot         <= '0;
      result.kernel_count       <= count_next;
      result.dimension_mismatch <= last && (count_next != expected);
    end
  end

endmodule

`default_nettype wire

// File: src/gf2_kernel_basis_elimination_top.sv
// ----------------------------------------------------------------------------
// gf2_kernel_basis_elimination_top
// Incremental GF(2) elimination producing kernel vectors and a dimension check.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high and cannot be held off, so the
// receiver must take it then. One item is worked at a time: the vector is
// scanned one bit position per cycle from the top down, save where a stored
// pivot is applied and the scan waits on the registered pivot RAM read.
// A remainder that turns zero finishes at once. A new item may be started in
// the cycle done is high. Pivot slots carry valid bits cleared by reset or
// start_new, so no clearing pass is needed. The expected kernel dimension is
// written through cfg while the block is idle.
`default_nettype none

module gf2_kernel_basis_elimination_top #(
  parameter int unsigned VECTOR_WIDTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire gke_pkg::item_t             item,
  output logic                            busy,
  output logic                            done,
  output gke_pkg::result_t                result,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [gke_pkg::CountW-1:0] cfg_data
);

  gke_pkg::dp_cmd_t    cmd;
  gke_pkg::dp_status_t status;

  assign cfg_ready = !busy;

  gke_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  gke_datapath #(
    .VECTOR_WIDTH (VECTOR_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

`default_nettype wire

// File: src/gke_checker.sv
// ----------------------------------------------------------------------------
// gke_port_checks
// Port-level checks on the command handshake and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module gke_port_checks (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire gke_pkg::result_t result
);

  // an accepted item keeps the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  // busy only drops when a result is delivered
  a_busy_drop: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without result");

  // dependent results carry no pivot slot
  a_dep_slot: assert property (@(posedge clk) disable iff (rst)
    done && result.dependent |-> result.pivot_slot == '0)
    else $error("pivot slot set on dependent result");

  // count saturates
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> result.kernel_count <= gke_pkg::CountMax)
    else $error("kernel count above limit");

endmodule

bind gf2_kernel_basis_elimination_top gke_port_checks u_gke_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// File: tb/gke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gke_checker
// Watches the item, result and config channels of the elimination block. It
// keeps its own pivot table, predicts each result at item transfer and
// compares results in order, field by field.
// ----------------------------------------------------------------------------
module gke_checker #(
  parameter int unsigned VECTOR_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  gke_pkg::item_t             item,
  input  logic                       done,
  input  gke_pkg::result_t           result,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [gke_pkg::CountW-1:0] cfg_data,
  output int                         mismatch_count,
  output int                         results_owed
);
  import gke_pkg::*;

  localparam logic [VecPortW-1:0] VecMask =
    (VECTOR_WIDTH >= VecPortW) ? {VecPortW{1'b1}} : ((64'd1 << VECTOR_WIDTH) - 64'd1);

  logic [VecPortW-1:0] pivot_vec [VecPortW];
  logic [TagW-1:0]     pivot_tag [VecPortW];
  logic [CountW-1:0]   kernel_found;
  logic [CountW-1:0]   kernel_dim_cfg;
  result_t             due_results [$];

  function automatic void clear_pivots();
    int i;
    for (i = 0; i < VecPortW; i++) begin
      pivot_vec[i] = '0;
      pivot_tag[i] = '0;
    end
    kernel_found = '0;
  endfunction

  // reduce one vector against the table, updating the table and the count
  function automatic result_t eliminate_vector(input item_t it);
    logic [VecPortW-1:0] v;
    logic [TagW-1:0]     t;
    logic [SlotW-1:0]    lead;
    int                  b;
    bit                  finished;
    result_t             r;
    v        = it.vector_in & VecMask;
    t        = it.combination_in;
    r        = '0;
    lead     = '0;
    finished = 1'b0;
    if (it.start_new) clear_pivots();
    while (!finished) begin
      if (v == '0) begin
        r.dependent = 1'b1;
        finished    = 1'b1;
      end else begin
        for (b = 0; b < VECTOR_WIDTH; b++) begin
          if (v[b]) lead = SlotW'(b);
        end
        if (pivot_vec[lead] != '0) begin
          v = v ^ pivot_vec[lead];
          t = t ^ pivot_tag[lead];
        end else begin
          pivot_vec[lead] = v;
          pivot_tag[lead] = t;
          r.pivot_slot    = lead;
          finished        = 1'b1;
        end
      end
    end
    if (r.dependent && kernel_found < CountMax) kernel_found = kernel_found + 1'b1;
    r.kernel_vector      = t;
    r.kernel_count       = kernel_found;
    r.dimension_mismatch = it.last_in_set && (kernel_found != kernel_dim_cfg);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("t=%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_pivots();
      kernel_dim_cfg = '0;
      due_results.delete();
      mismatch_count = 0;
    end else begin
      // a result can retire in the same cycle a new item is taken
      if (done !== 1'b0) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          $display("t=%0t unexpected result: expected none, actual %h", $time, result);
        end else begin
          want = due_results.pop_front();
          check_field("dependent", want.dependent, result.dependent);
          check_field("kernel_vector", want.kernel_vector, result.kernel_vector);
          check_field("pivot_slot", want.pivot_slot, result.pivot_slot);
          check_field("kernel_count", want.kernel_count, result.kernel_count);
          check_field("dimension_mismatch", want.dimension_mismatch,
                      result.dimension_mismatch);
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) kernel_dim_cfg = cfg_data;
      if (start && busy === 1'b0) due_results = {due_results, eliminate_vector(item)};
    end
    results_owed = due_results.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the GF(2) elimination block: directed corner items, then sets
// of low-rank vectors with random tags under random gaps, across several
// expected kernel dimensions. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import gke_pkg::*;

  localparam int unsigned VectorWidth = 64;
  localparam int          ItemTarget  = 1900;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  item_t               item      = '0;
  logic                busy;
  logic                done;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CountW-1:0]   cfg_data  = '0;
  int                  mismatch_count;
  int                  results_owed;
  int                  items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gf2_kernel_basis_elimination_top #(
    .VECTOR_WIDTH(VectorWidth)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  gke_checker #(
    .VECTOR_WIDTH(VectorWidth)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .done          (done),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t mk_item(input logic fresh, input logic [63:0] v,
                                    input logic [63:0] t, input logic last);
    item_t it;
    it.start_new      = fresh;
    it.vector_in      = v;
    it.combination_in = t;
    it.last_in_set    = last;
    return it;
  endfunction

  // start stays high after a transfer until the next negedge, where it is
  // either lowered for a gap or carries the next item
  task automatic send_item(input item_t it);
    int gap;
    gap = $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_kernel_dim(input logic [CountW-1:0] dim);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dim;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // vectors drawn from the span of a few bases, so dependent ones show up
  task automatic run_set(input int n_items, input int rank, input bit fresh);
    logic [63:0] bases [8];
    logic [63:0] v;
    int          i;
    int          k;
    int          sel;
    for (k = 0; k < rank; k++) bases[k] = rand64() >> $urandom_range(0, 63);
    for (i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, (1 << rank) - 1);
      v   = '0;
      for (k = 0; k < rank; k++) begin
        if (sel[k]) v = v ^ bases[k];
      end
      if ($urandom_range(0, 15) == 0) v = rand64();
      send_item(mk_item((i == 0) ? fresh : ($urandom_range(0, 40) == 0), v, rand64(),
                        (i == n_items - 1) || ($urandom_range(0, 30) == 0)));
    end
  endtask

  initial begin
    logic [63:0] v1;
    logic [63:0] v2;
    logic [6:0]  dim;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero vector is dependent at once; expected dimension still at reset value
    send_item(mk_item(1'b1, '0, '1, 1'b1));
    send_item(mk_item(1'b1, '1, '0, 1'b0));
    send_item(mk_item(1'b0, 64'h1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0));
    send_item(mk_item(1'b0, 64'h8000_0000_0000_0001, rand64(), 1'b0));
    send_item(mk_item(1'b0, '1, '1, 1'b1));
    // table kept after the last item: long chain down to zero
    send_item(mk_item(1'b0, 64'h8000_0000_0000_0000, rand64(), 1'b0));
    send_item(mk_item(1'b0, 64'h2, rand64(), 1'b0));

    // count matches the expected dimension on the last item
    write_kernel_dim(7'd2);
    v1 = rand64();
    v2 = rand64() >> 7;
    send_item(mk_item(1'b1, v1, rand64(), 1'b0));
    send_item(mk_item(1'b0, v2, rand64(), 1'b0));
    send_item(mk_item(1'b0, v1 ^ v2, rand64(), 1'b0));
    send_item(mk_item(1'b0, v2, rand64(), 1'b1));

    // expected dimension above 64 can never match
    write_kernel_dim(7'd127);
    send_item(mk_item(1'b1, 64'h4000_0000_0000_0000, rand64(), 1'b1));
    write_kernel_dim(7'd0);
    send_item(mk_item(1'b1, '0, rand64(), 1'b1));
    send_item(mk_item(1'b1, 64'h5, rand64(), 1'b1));

    // long low-rank set to push the count toward saturation
    write_kernel_dim(7'd64);
    run_set(75, 2, 1'b1);

    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 5))
        0:       dim = 7'd0;
        1:       dim = 7'd64;
        2:       dim = 7'd127;
        default: dim = 7'($urandom_range(0, 8));
      endcase
      write_kernel_dim(dim);
      repeat ($urandom_range(3, 8)) begin
        run_set($urandom_range(1, 14), $urandom_range(1, 8), $urandom_range(0, 9) != 0);
      end
    end

    drain_results();
    repeat (140) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
